/* sv/kftl_pkg.sv */
// shared types and constants for the keyframe timeline player
// no dependencies; imported by every module of the block
package kftl_pkg;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_RESYNC = 2'd3;

  localparam logic [1:0] REG_ENTRY_COUNT = 2'd0;
  localparam logic [1:0] REG_TOTAL_TICKS = 2'd1;
  localparam logic [1:0] REG_FRAME_COUNT = 2'd2;

  // shown frame marker: bit 8 set means nothing on screen
  localparam logic [8:0] NO_FRAME = 9'h100;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  // a running sum of at most 256 durations of 255 ticks fits 16 bits
  localparam int SUM_W = 16;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] idx;
    logic [7:0] frame;
    logic [7:0] ticks;
    logic       load_bad;
  } cmd_t;

endpackage

/* sv/kftl_front.sv */
// input stage: takes stream beats, drops loads beyond the store, judges load validity
// depends on kftl_pkg
module kftl_front #(
  parameter int MAX_ENTRIES = 192
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_op,
  input  logic [7:0]        in_idx,
  input  logic [7:0]        in_frame,
  input  logic [7:0]        in_ticks,
  input  logic [8:0]        frame_count,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output kftl_pkg::cmd_t    cmd
);
  import kftl_pkg::*;

  logic keep;
  cmd_t cmd_next;

  assign in_ready  = !cmd_valid || cmd_ready;

  always_comb begin
    cmd_next.op       = in_op;
    cmd_next.idx      = in_idx;
    cmd_next.frame    = in_frame;
    cmd_next.ticks    = in_ticks;
    cmd_next.load_bad = (in_ticks == 8'd0) || ({1'b0, in_frame} >= frame_count);
    // loads beyond the store have no effect at all
    keep = (in_op != OP_LOAD) || ({1'b0, in_idx} < 9'(MAX_ENTRIES));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_ready) begin
      cmd_valid <= in_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cmd <= cmd_next;
    end
  end

endmodule

/* sv/kftl_queue.sv */
// short command queue between the input stage and the sequencer
// depends on kftl_pkg
module kftl_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  kftl_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output kftl_pkg::cmd_t pop_cmd
);
  import kftl_pkg::*;

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != (QPTR_W+1)'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

/* sv/kftl_back.sv */
// sequencer: timeline store, tick counter, entry walk and result register
// depends on kftl_pkg
module kftl_back #(
  parameter int MAX_ENTRIES = 192
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  kftl_pkg::cmd_t cmd,
  input  logic [7:0]     entry_count,
  input  logic [15:0]    total_ticks,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_frame,
  output logic [15:0]    out_tick
);
  import kftl_pkg::*;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic [15:0]      mem [MAX_ENTRIES];
  logic [15:0]      rd_data;
  logic [IDX_W-1:0] rd_addr;

  logic             state;
  logic [IDX_W-1:0] idx;
  logic [SUM_W-1:0] sum;
  logic [15:0]      tick_counter;
  logic [8:0]       shown_frame;
  logic             timeline_bad;
  logic             running;
  logic             emit_always;

  logic             dispatch;
  logic [IDX_W-1:0] last_idx;
  logic             start_ok;
  logic [16:0]      tick_inc;
  logic [15:0]      tick_next;
  logic [SUM_W-1:0] sum_next;
  logic             walk_done;

  assign cmd_ready = (state == ST_IDLE) && !out_valid;
  assign dispatch  = cmd_valid && cmd_ready;

  always_comb begin
    if (entry_count == 8'd0) begin
      last_idx = '0;
    end else if ({1'b0, entry_count} > 9'(MAX_ENTRIES)) begin
      last_idx = IDX_W'(MAX_ENTRIES - 1);
    end else begin
      last_idx = IDX_W'(entry_count - 8'd1);
    end
    start_ok  = !timeline_bad && (entry_count != 8'd0) &&
                ({1'b0, entry_count} <= 9'(MAX_ENTRIES)) && (total_ticks != 16'd0);
    tick_inc  = {1'b0, tick_counter} + 17'd1;
    tick_next = (tick_inc >= {1'b0, total_ticks}) ? 16'd0 : tick_inc[15:0];
    sum_next  = sum + SUM_W'(rd_data[15:8]);
    walk_done = (tick_counter < sum_next) || (idx == last_idx);
    // the walk prefetches the following entry; entry zero is fetched when idle
    rd_addr   = (state == ST_WALK) ? idx + 1'b1 : '0;
  end

  always_ff @(posedge clk) begin
    if (dispatch && cmd.op == OP_LOAD) begin
      mem[cmd.idx[IDX_W-1:0]] <= {cmd.ticks, cmd.frame};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      tick_counter <= '0;
      shown_frame  <= NO_FRAME;
      timeline_bad <= 1'b0;
      running      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (dispatch) begin
            case (cmd.op)
              OP_LOAD: begin
                timeline_bad <= cmd.load_bad || (timeline_bad && cmd.idx != 8'd0);
              end
              OP_START: begin
                shown_frame <= NO_FRAME;
                running     <= start_ok;
                if (start_ok) begin
                  tick_counter <= '0;
                  state        <= ST_WALK;
                end
              end
              OP_TICK: begin
                if (running) begin
                  if (shown_frame == NO_FRAME) begin
                    // resync: show the current frame again without advancing
                  end else begin
                    tick_counter <= tick_next;
                  end
                  state <= ST_WALK;
                end
              end
              default: begin
                shown_frame <= NO_FRAME;
              end
            endcase
          end
        end
        ST_WALK: begin
          if (walk_done) begin
            state <= ST_IDLE;
            if (emit_always || {1'b0, rd_data[7:0]} != shown_frame) begin
              out_valid   <= 1'b1;
              shown_frame <= {1'b0, rd_data[7:0]};
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      idx         <= '0;
      sum         <= '0;
      emit_always <= (cmd.op == OP_START) || (shown_frame == NO_FRAME);
    end else begin
      idx <= idx + 1'b1;
      sum <= sum_next;
    end
    if (state == ST_WALK && walk_done) begin
      out_frame <= rd_data[7:0];
      out_tick  <= tick_counter;
    end
  end

  a_walk_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> !out_valid)
    else $error("walk running while a result is pending");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (idx <= last_idx))
    else $error("walk passed the last entry in use");

  a_shown_matches: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (shown_frame == {1'b0, out_frame}))
    else $error("emitted frame differs from shown frame");

  a_walk_needs_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> running)
    else $error("walk while not running");

endmodule

/* sv/keyframe_timeline_player_core.sv */
// top level of the keyframe timeline player: apb registers, input stage, queue, sequencer
// depends on kftl_pkg, kftl_front, kftl_queue and kftl_back
// path: a beat is registered in the input stage and queued; a start or tick taken by the sequencer
// walks k entries (1 up to entry_count), then registers any result; loads write the store
// throughput: a walking start or tick holds the sequencer through its walk and, if it emits, until
// the result is taken; loads, resyncs and ignored items go at one per cycle while nothing holds it
// reset: synchronous; registers read 1, not running, no frame shown, store contents undefined
module keyframe_timeline_player_core #(
  parameter int MAX_ENTRIES = 192
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // entry_index[7:0], entry_frame[15:8], entry_ticks[23:16]
  input  logic [1:0]  s_tuser,   // op[1:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // frame[7:0], tick_position[23:8]
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import kftl_pkg::*;

  logic [7:0]  entry_count;
  logic [15:0] total_ticks;
  logic [8:0]  frame_count;
  logic        reg_wr;

  logic        f_valid;
  logic        f_ready;
  cmd_t        f_cmd;
  logic        q_valid;
  logic        q_ready;
  cmd_t        q_cmd;
  logic [7:0]  out_frame;
  logic [15:0] out_tick;

  // register file, written on the access phase of an apb write
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= 8'd1;
      total_ticks <= 16'd1;
      frame_count <= 9'd1;
    end else if (reg_wr) begin
      case (paddr[3:2])
        REG_ENTRY_COUNT: entry_count <= pwdata[7:0];
        REG_TOTAL_TICKS: total_ticks <= pwdata[15:0];
        REG_FRAME_COUNT: frame_count <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ENTRY_COUNT: prdata = {24'd0, entry_count};
      REG_TOTAL_TICKS: prdata = {16'd0, total_ticks};
      REG_FRAME_COUNT: prdata = {23'd0, frame_count};
      default:         prdata = 32'd0;
    endcase
  end

  // input stage: classifies each beat and judges load validity up front
  kftl_front #(.MAX_ENTRIES(MAX_ENTRIES)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_op       (s_tuser),
    .in_idx      (s_tdata[7:0]),
    .in_frame    (s_tdata[15:8]),
    .in_ticks    (s_tdata[23:16]),
    .frame_count (frame_count),
    .cmd_valid   (f_valid),
    .cmd_ready   (f_ready),
    .cmd         (f_cmd)
  );

  // decouples intake from the walk so beats keep arriving, until the queue fills, while a result waits
  kftl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  // sequencer: one command at a time, walking the timeline one entry per cycle
  kftl_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (q_valid),
    .cmd_ready   (q_ready),
    .cmd         (q_cmd),
    .entry_count (entry_count),
    .total_ticks (total_ticks),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_frame   (out_frame),
    .out_tick    (out_tick)
  );

  assign m_tdata = {out_tick, out_frame};

endmodule
